// ----- sv/gmwf_pkg.sv -----
// Shared types and constants for the grid maze wall follower.
// Holds opcodes, cell kinds, status codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package gmwf_pkg;

  // Coordinates are 4 bits wide, so at most 16 rows and columns are reachable
  localparam int unsigned COORD_W       = 4;
  localparam int unsigned COORD_MAX_DIM = 16;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_STEP    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] KIND_OPEN    = 2'd0;
  localparam logic [1:0] KIND_WALL    = 2'd1;
  localparam logic [1:0] KIND_OUTSIDE = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  localparam logic [2:0] ST_ACK   = 3'd0;
  localparam logic [2:0] ST_MOVED = 3'd1;
  localparam logic [2:0] ST_EXIT  = 3'd2;
  localparam logic [2:0] ST_STUCK = 3'd3;
  localparam logic [2:0] ST_ERROR = 3'd4;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [1:0] CFG_START_ROW    = 2'd0;
  localparam logic [1:0] CFG_START_COL    = 2'd1;
  localparam logic [1:0] CFG_START_FACING = 2'd2;

  // Probe 0 is the walker's own cell, probes 1 to 4 the neighbors
  localparam logic [2:0] PROBE_SELF = 3'd0;
  localparam logic [2:0] PROBE_LAST = 3'd4;

  typedef struct packed {
    logic       write_cell;
    logic       restart;
    logic       advance;
    logic       move;
    logic       set_res;
    logic       latch_final;
    logic [2:0] res_code;
    logic       load_out;
  } gmwf_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       tag_self;
    logic       tag_last;
    logic [2:0] final_status;
    logic       out_busy;
  } gmwf_stat_t;

  // Heading offset for each neighbor probe: right, front, left, back
  function automatic logic [1:0] turn_offset(input logic [2:0] probe);
    logic [1:0] off;
    unique case (probe)
      3'd1:    off = 2'd1;
      3'd2:    off = 2'd0;
      3'd3:    off = 2'd3;
      3'd4:    off = 2'd2;
      default: off = 2'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ----- sv/gmwf_ctrl.sv -----
// Controller state machine of the grid maze wall follower.
// Sequences transactions and the neighbor scan; drives gmwf_datapath by commands.
// Depends on gmwf_pkg.
`default_nettype none

module gmwf_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [1:0]          opcode_i,
  output logic                     in_ready_o,
  input  wire gmwf_pkg::gmwf_stat_t stat_i,
  output gmwf_pkg::gmwf_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = gmwf_pkg::ST_ACK;
          state_d        = S_FINISH;
          unique case (opcode_i)
            gmwf_pkg::OP_WRITE: begin
              cmd_o.write_cell = 1'b1;
            end
            gmwf_pkg::OP_STEP: begin
              if (stat_i.final_status != gmwf_pkg::ST_ACK) begin
                // Walk has ended: repeat the latched status
                cmd_o.res_code = stat_i.final_status;
              end else begin
                cmd_o.set_res = 1'b0;
                cmd_o.advance = 1'b1;
                state_d       = S_SCAN;
              end
            end
            gmwf_pkg::OP_RESTART: begin
              cmd_o.restart = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (stat_i.tag_self) begin
          if (stat_i.kind == gmwf_pkg::KIND_OUTSIDE) begin
            cmd_o.set_res     = 1'b1;
            cmd_o.latch_final = 1'b1;
            cmd_o.res_code    = gmwf_pkg::ST_EXIT;
            state_d           = S_FINISH;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end else begin
          cmd_o.set_res  = 1'b1;
          state_d        = S_FINISH;
          unique case (stat_i.kind)
            gmwf_pkg::KIND_WALL: begin
              if (stat_i.tag_last) begin
                cmd_o.latch_final = 1'b1;
                cmd_o.res_code    = gmwf_pkg::ST_STUCK;
              end else begin
                // Skip the wall, keep scanning
                cmd_o.set_res = 1'b0;
                cmd_o.advance = 1'b1;
                state_d       = S_SCAN;
              end
            end
            gmwf_pkg::KIND_OPEN: begin
              cmd_o.move     = 1'b1;
              cmd_o.res_code = gmwf_pkg::ST_MOVED;
            end
            gmwf_pkg::KIND_OUTSIDE: begin
              cmd_o.latch_final = 1'b1;
              cmd_o.res_code    = gmwf_pkg::ST_EXIT;
            end
            default: begin
              cmd_o.latch_final = 1'b1;
              cmd_o.res_code    = gmwf_pkg::ST_ERROR;
            end
          endcase
        end
      end

      S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/gmwf_datapath.sv -----
// Datapath of the grid maze wall follower: grid memory with valid bits,
// walker and start registers, probe address generation and the output register.
// Depends on gmwf_pkg; driven by gmwf_ctrl.
`default_nettype none

module gmwf_datapath #(
  parameter int unsigned GRID_DIM = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gmwf_pkg::gmwf_cmd_t cmd_i,
  output gmwf_pkg::gmwf_stat_t     stat_o,
  input  wire logic [3:0]          cell_row_i,
  input  wire logic [3:0]          cell_col_i,
  input  wire logic [1:0]          cell_kind_i,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [3:0]          cfg_wdata_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [2:0]               status_o,
  output logic [3:0]               pos_row_o,
  output logic [3:0]               pos_col_o,
  output logic [1:0]               heading_o
);

  localparam int unsigned EFF_DIM = (GRID_DIM < gmwf_pkg::COORD_MAX_DIM) ?
                                    GRID_DIM : gmwf_pkg::COORD_MAX_DIM;
  localparam int unsigned RW      = $clog2(EFF_DIM);
  localparam int unsigned DEPTH   = 1 << (2 * RW);
  localparam int unsigned AW      = 2 * RW;
  localparam logic [4:0]  DIM_LIM = 5'(EFF_DIM);

  // Grid store and per-entry valid bits; an entry never written reads as outside
  logic [1:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_q;

  logic [3:0] walk_row_q, walk_col_q;
  logic [1:0] walk_dir_q;
  logic [2:0] final_q;
  logic [3:0] start_row_q, start_col_q;
  logic [1:0] start_dir_q;

  logic [2:0] probe_q, probe_d;
  logic [2:0] tag_q;
  logic [1:0] rd_kind_q;
  logic       rd_vld_q;
  logic       rd_oob_q;
  logic [3:0] nb_row_q, nb_col_q;
  logic [1:0] nb_dir_q;
  logic [2:0] res_q;

  logic       out_valid_q;
  logic [2:0] out_status_q;
  logic [3:0] out_row_q, out_col_q;
  logic [1:0] out_dir_q;

  logic [1:0]    pr_dir;
  logic [4:0]    pr_row, pr_col;
  logic          pr_oob;
  logic [AW-1:0] raddr, waddr;
  logic          wr_in_grid;

  // Probe coordinates: own cell for probe 0, else the neighbor in turn order
  always_comb begin
    pr_dir = walk_dir_q + gmwf_pkg::turn_offset(probe_q);
    pr_row = {1'b0, walk_row_q};
    pr_col = {1'b0, walk_col_q};
    if (probe_q != gmwf_pkg::PROBE_SELF) begin
      unique case (pr_dir)
        gmwf_pkg::DIR_UP:    pr_row = {1'b0, walk_row_q} - 5'd1;
        gmwf_pkg::DIR_RIGHT: pr_col = {1'b0, walk_col_q} + 5'd1;
        gmwf_pkg::DIR_DOWN:  pr_row = {1'b0, walk_row_q} + 5'd1;
        default:             pr_col = {1'b0, walk_col_q} - 5'd1;
      endcase
    end
    // A step below zero wraps high, so one compare covers both edges
    pr_oob = (pr_row >= DIM_LIM) || (pr_col >= DIM_LIM);
  end

  assign raddr      = {pr_row[RW-1:0], pr_col[RW-1:0]};
  assign waddr      = {cell_row_i[RW-1:0], cell_col_i[RW-1:0]};
  assign wr_in_grid = ({1'b0, cell_row_i} < DIM_LIM) && ({1'b0, cell_col_i} < DIM_LIM);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_cell && wr_in_grid) begin
      mem[waddr] <= cell_kind_i;
    end
    rd_kind_q <= mem[raddr];
    rd_vld_q  <= vld_q[raddr];
    rd_oob_q  <= pr_oob;
    nb_row_q  <= pr_row[3:0];
    nb_col_q  <= pr_col[3:0];
    nb_dir_q  <= pr_dir;
    tag_q     <= probe_q;
    if (cmd_i.set_res) begin
      res_q <= cmd_i.res_code;
    end
  end

  // Hold the probe counter at zero while idle so the own cell is read ahead
  assign probe_d = cmd_i.advance ? probe_q + 3'd1 : gmwf_pkg::PROBE_SELF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      probe_q     <= gmwf_pkg::PROBE_SELF;
      walk_row_q  <= '0;
      walk_col_q  <= '0;
      walk_dir_q  <= gmwf_pkg::DIR_RIGHT;
      final_q     <= gmwf_pkg::ST_ACK;
      start_row_q <= '0;
      start_col_q <= '0;
      start_dir_q <= gmwf_pkg::DIR_RIGHT;
      out_valid_q <= 1'b0;
    end else begin
      probe_q <= probe_d;
      if (cmd_i.write_cell && wr_in_grid) begin
        vld_q[waddr] <= 1'b1;
      end
      if (cmd_i.restart) begin
        walk_row_q <= start_row_q;
        walk_col_q <= start_col_q;
        walk_dir_q <= start_dir_q;
        final_q    <= gmwf_pkg::ST_ACK;
      end else if (cmd_i.move) begin
        walk_row_q <= nb_row_q;
        walk_col_q <= nb_col_q;
        walk_dir_q <= nb_dir_q;
      end
      if (cmd_i.latch_final) begin
        final_q <= cmd_i.res_code;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gmwf_pkg::CFG_START_ROW:    start_row_q <= cfg_wdata_i;
          gmwf_pkg::CFG_START_COL:    start_col_q <= cfg_wdata_i;
          gmwf_pkg::CFG_START_FACING: start_dir_q <= cfg_wdata_i[1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_q;
      out_row_q    <= walk_row_q;
      out_col_q    <= walk_col_q;
      out_dir_q    <= walk_dir_q;
    end
  end

  always_comb begin
    stat_o              = '0;
    stat_o.kind         = (rd_oob_q || !rd_vld_q) ? gmwf_pkg::KIND_OUTSIDE : rd_kind_q;
    stat_o.tag_self     = (tag_q == gmwf_pkg::PROBE_SELF);
    stat_o.tag_last     = (tag_q == gmwf_pkg::PROBE_LAST);
    stat_o.final_status = final_q;
    stat_o.out_busy     = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign pos_row_o   = out_row_q;
  assign pos_col_o   = out_col_q;
  assign heading_o   = out_dir_q;

endmodule

`default_nettype wire

// ----- sv/grid_maze_wall_follower_top.sv -----
// Grid maze right-hand wall follower.
// Input channel (valid/ready): opcode write cell, walk step or restart, plus cell
// coordinates and kind. Output channel (valid/ready): status, walker position and
// heading, one result per input transaction, in order.
// Configuration: cfg_we_i writes start_row, start_col or start_facing by index;
// write only while no transaction is outstanding.
// A write, restart or ended-walk step goes straight to the finish state; a live
// step first probes one cell per cycle, since the own cell and up to four
// neighbors come through the single grid read port.
// One item is in flight at a time; in_ready_o is high once the previous result
// sits in the output register, so a stalled receiver blocks after one more item.
// Reset: every cell reads as outside, walker at row 0, column 0 facing right,
// start registers at the same values; no clearing pass is needed.
// Depends on gmwf_pkg, gmwf_ctrl and gmwf_datapath.
`default_nettype none

module grid_maze_wall_follower_top #(
  parameter int unsigned GRID_DIM = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] opcode_i,
  input  wire logic [3:0] cell_row_i,
  input  wire logic [3:0] cell_col_i,
  input  wire logic [1:0] cell_kind_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      status_o,
  output logic [3:0]      pos_row_o,
  output logic [3:0]      pos_col_o,
  output logic [1:0]      heading_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [3:0] cfg_wdata_i
);

  gmwf_pkg::gmwf_cmd_t  cmd;
  gmwf_pkg::gmwf_stat_t stat;

  gmwf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gmwf_datapath #(
    .GRID_DIM (GRID_DIM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cell_row_i  (cell_row_i),
    .cell_col_i  (cell_col_i),
    .cell_kind_i (cell_kind_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .pos_row_o   (pos_row_o),
    .pos_col_o   (pos_col_o),
    .heading_o   (heading_o)
  );

endmodule

`default_nettype wire

// ----- sv/gmwf_checker.sv -----
// Port-level checks for grid_maze_wall_follower_top, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module gmwf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [2:0] status_o,
  input wire logic [3:0] pos_row_o,
  input wire logic [3:0] pos_col_o,
  input wire logic [1:0] heading_o
);

  // Stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(pos_row_o) && $stable(pos_col_o) && $stable(heading_o))
    else $error("result changed while stalled");

  // Status codes stay within the defined set
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= 3'd4)
    else $error("undefined status code");

  // One item in flight: no second acceptance right after one
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // A fresh result only appears after an accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o || $past(!in_ready_o))
    else $error("result without an accepted item");

endmodule

bind grid_maze_wall_follower_top gmwf_checker u_gmwf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .pos_row_o   (pos_row_o),
  .pos_col_o   (pos_col_o),
  .heading_o   (heading_o)
);

`default_nettype wire
